@@ rtl/usbreq_pkg.sv @@
// Package for the USB standard-request handler: codes, widths and helper functions.
`default_nettype none

package usbreq_pkg;

  // Number of endpoints with a halt bit (endpoint 0 included), 1 to 16.
  localparam int NUM_ENDPOINTS = 8;

  localparam int IN_TDATA_W   = 48;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_TDATA_W  = 80;
  localparam int OUT_TUSER_W  = 3;

  localparam logic [15:0] SERIAL_SELECTOR = 16'h03DC;
  localparam logic [6:0]  ADDR_MASK       = 7'h7F;

  typedef enum logic [1:0] {
    OP_SETUP     = 2'd0,
    OP_SUSPEND   = 2'd1,
    OP_RESUME    = 2'd2,
    OP_BUS_RESET = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_STALL  = 3'd1,
    ACT_ACK    = 3'd2,
    ACT_REPLY1 = 3'd3,
    ACT_REPLY2 = 3'd4,
    ACT_SERIAL = 3'd5,
    ACT_DESC   = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_UNATTACHED = 3'd0,
    ST_POWERED    = 3'd1,
    ST_DEFAULT    = 3'd2,
    ST_ADDRESSED  = 3'd3,
    ST_CONFIGURED = 3'd4,
    ST_SUSPENDED  = 3'd5
  } dev_state_t;

  typedef enum logic [1:0] {
    EP_CMD_NONE  = 2'd0,
    EP_CMD_HALT  = 2'd1,
    EP_CMD_CLEAR = 2'd2
  } ep_cmd_t;

  // Standard request codes (bRequest).
  localparam logic [7:0] REQ_STATUS     = 8'd0;
  localparam logic [7:0] REQ_FEAT_CLR   = 8'd1;
  localparam logic [7:0] REQ_FEAT_SET   = 8'd3;
  localparam logic [7:0] REQ_ADDR_SET   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC   = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG = 8'd9;

  // bmRequestType values accepted.
  localparam logic [7:0] RT_OUT_DEVICE   = 8'h00;
  localparam logic [7:0] RT_OUT_ENDPOINT = 8'h02;
  localparam logic [7:0] RT_IN_DEVICE    = 8'h80;
  localparam logic [7:0] RT_IN_INTERFACE = 8'h81;
  localparam logic [7:0] RT_IN_ENDPOINT  = 8'h82;

  localparam logic [15:0] WAKEUP_FEATURE_SEL = 16'd1;

  // State the device settles in when it leaves suspend or changes configuration.
  function automatic dev_state_t idle_state(input logic [7:0] cfg, input logic [6:0] addr);
    dev_state_t s;
    if (cfg != 8'd0) begin
      s = ST_CONFIGURED;
    end else if (addr != 7'd0) begin
      s = ST_ADDRESSED;
    end else begin
      s = ST_POWERED;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/usb_standard_request_handler.sv @@
// Top level of the USB standard-request handler: event decode, device state and result register.
`default_nettype none

// USB device standard-request engine.
// The input channel carries one event per transfer: a SETUP packet, suspend, resume or
// bus reset. The event kind and the "already handled by the application" flag travel in
// in_tuser; the eight setup bytes travel in in_tdata. For every event exactly one result
// transfer follows on the output channel: the action code in out_tuser, and in out_tdata
// the reply word, descriptor request, endpoint command and a snapshot of the device
// state, address, configuration and remote-wakeup flag as they stand after the event.
// The result of an event is registered as the event is accepted and presented from the
// next edge on. Throughput is one event per cycle while out_tready stays high; the only
// storage in the path is the single result register, refilled in the same cycle it is drained.
// When the receiver stalls, the result register holds its transfer and in_tready drops,
// so no event is taken until the waiting result has gone.
// Reset (rst_n low, synchronous) puts the device in the unattached state with address,
// configuration, remote wakeup and all endpoint halt bits cleared, and empties the result
// register. A bus reset event sets the default state and clears all else but remote wakeup.
module usb_standard_request_handler (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [7:0] request_type, [15:8] request_code, [31:16] value_word, [47:32] index_word
  input  wire logic [usbreq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] opcode, [2] app_handled
  input  wire logic [usbreq_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [15:0] reply_data, [31:16] descriptor_selector, [47:32] descriptor_language,
  // [49:48] endpoint_command, [53:50] endpoint_target, [56:54] device_state,
  // [63:57] device_address, [71:64] configuration_value, [72] remote_wakeup,
  // [79:73] zero
  output logic [usbreq_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [2:0] action
  output logic [usbreq_pkg::OUT_TUSER_W-1:0]        out_tuser
);

  localparam int NEP = usbreq_pkg::NUM_ENDPOINTS;

  // Device state registers.
  usbreq_pkg::dev_state_t state_r, state_nxt;
  logic [6:0]             addr_r, addr_nxt;
  logic [7:0]             config_r, config_nxt;
  logic                   wakeup_r, wakeup_nxt;
  logic [NEP-1:0]         halt_r, halt_nxt;

  // Result register.
  logic                               out_valid_r;
  logic [usbreq_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [usbreq_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  // Decoded input fields.
  usbreq_pkg::opcode_t opcode;
  logic                handled;
  logic [7:0]          rtype;
  logic [7:0]          rcode;
  logic [15:0]         wval;
  logic [15:0]         widx;
  logic [3:0]          ep;
  logic [NEP-1:0]      ep_sel;
  logic                ep_ok;
  logic                in_fire;

  // Result fields.
  usbreq_pkg::action_t action;
  usbreq_pkg::ep_cmd_t ecmd;
  logic [15:0]         reply;
  logic [15:0]         dsel;
  logic [15:0]         dlang;
  logic [3:0]          etgt;

  assign opcode  = usbreq_pkg::opcode_t'(in_tuser[1:0]);
  assign handled = in_tuser[2];
  assign rtype   = in_tdata[7:0];
  assign rcode   = in_tdata[15:8];
  assign wval    = in_tdata[31:16];
  assign widx    = in_tdata[47:32];
  assign ep      = widx[3:0];

  // A new transfer is taken whenever the result register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // One-hot endpoint select; an endpoint number beyond the table selects nothing.
  always_comb begin
    for (int i = 0; i < NEP; i++) begin
      ep_sel[i] = (ep == 4'(i));
    end
  end

  // Halt commands are refused on endpoint 0 and on endpoints that do not exist.
  assign ep_ok = (ep != 4'd0) && ({1'b0, ep} < 5'(NEP));

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    config_nxt = config_r;
    wakeup_nxt = wakeup_r;
    halt_nxt   = halt_r;
    action     = usbreq_pkg::ACT_NONE;
    ecmd       = usbreq_pkg::EP_CMD_NONE;
    reply      = 16'd0;
    dsel       = 16'd0;
    dlang      = 16'd0;
    etgt       = 4'd0;

    case (opcode)
      usbreq_pkg::OP_SUSPEND: begin
        state_nxt = usbreq_pkg::ST_SUSPENDED;
      end
      usbreq_pkg::OP_RESUME: begin
        state_nxt = usbreq_pkg::idle_state(config_r, addr_r);
      end
      usbreq_pkg::OP_BUS_RESET: begin
        // Remote wakeup deliberately survives a bus reset.
        state_nxt  = usbreq_pkg::ST_DEFAULT;
        config_nxt = 8'd0;
        addr_nxt   = 7'd0;
        halt_nxt   = '0;
      end
      usbreq_pkg::OP_SETUP: begin
        if (state_r != usbreq_pkg::ST_UNATTACHED && !handled) begin
          action = usbreq_pkg::ACT_STALL;
          case (rcode)
            usbreq_pkg::REQ_STATUS: begin
              if (rtype == usbreq_pkg::RT_IN_DEVICE) begin
                reply  = {14'd0, wakeup_r, 1'b0};
                action = usbreq_pkg::ACT_REPLY2;
              end else if (rtype == usbreq_pkg::RT_IN_ENDPOINT) begin
                reply  = {15'd0, |(halt_r & ep_sel)};
                action = usbreq_pkg::ACT_REPLY2;
              end
            end
            usbreq_pkg::REQ_FEAT_CLR,
            usbreq_pkg::REQ_FEAT_SET: begin
              if (rtype == usbreq_pkg::RT_OUT_DEVICE) begin
                if (wval == usbreq_pkg::WAKEUP_FEATURE_SEL) begin
                  wakeup_nxt = (rcode == usbreq_pkg::REQ_FEAT_SET);
                  action     = usbreq_pkg::ACT_ACK;
                end
              end else if (rtype == usbreq_pkg::RT_OUT_ENDPOINT) begin
                // The feature selector is not checked for endpoints.
                if (ep_ok) begin
                  if (rcode == usbreq_pkg::REQ_FEAT_SET) begin
                    halt_nxt = halt_r | ep_sel;
                    ecmd     = usbreq_pkg::EP_CMD_HALT;
                  end else begin
                    halt_nxt = halt_r & ~ep_sel;
                    ecmd     = usbreq_pkg::EP_CMD_CLEAR;
                  end
                  etgt   = ep;
                  action = usbreq_pkg::ACT_ACK;
                end
              end
            end
            usbreq_pkg::REQ_ADDR_SET: begin
              if (rtype == usbreq_pkg::RT_OUT_DEVICE) begin
                addr_nxt  = wval[6:0] & usbreq_pkg::ADDR_MASK;
                state_nxt = (wval[6:0] != 7'd0) ? usbreq_pkg::ST_ADDRESSED
                                                : usbreq_pkg::ST_DEFAULT;
                action    = usbreq_pkg::ACT_ACK;
              end
            end
            usbreq_pkg::REQ_GET_DESC: begin
              if (rtype == usbreq_pkg::RT_IN_DEVICE || rtype == usbreq_pkg::RT_IN_INTERFACE) begin
                if (wval == usbreq_pkg::SERIAL_SELECTOR) begin
                  action = usbreq_pkg::ACT_SERIAL;
                end else begin
                  dsel   = wval;
                  dlang  = widx;
                  action = usbreq_pkg::ACT_DESC;
                end
              end
            end
            usbreq_pkg::REQ_GET_CONFIG: begin
              if (rtype == usbreq_pkg::RT_IN_DEVICE) begin
                reply  = {8'd0, config_r};
                action = usbreq_pkg::ACT_REPLY1;
              end
            end
            usbreq_pkg::REQ_SET_CONFIG: begin
              if (rtype == usbreq_pkg::RT_OUT_DEVICE) begin
                config_nxt = wval[7:0];
                state_nxt  = usbreq_pkg::idle_state(wval[7:0], addr_r);
                action     = usbreq_pkg::ACT_ACK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Result word carries the state as it stands after this event.
  assign out_tdata_nxt = {7'd0, wakeup_nxt, config_nxt, addr_nxt, 3'(state_nxt),
                          etgt, 2'(ecmd), dlang, dsel, reply};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= usbreq_pkg::ST_UNATTACHED;
      addr_r      <= 7'd0;
      config_r    <= 8'd0;
      wakeup_r    <= 1'b0;
      halt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        addr_r      <= addr_nxt;
        config_r    <= config_nxt;
        wakeup_r    <= wakeup_nxt;
        halt_r      <= halt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= 3'(action);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

@@ verif/tb_usb_standard_request_handler.sv @@
// Self-checking testbench for the USB standard-request handler: directed and random events.
module tb_usb_standard_request_handler;
  import usbreq_pkg::*;

  localparam int N_RANDOM    = 1000;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    opcode_t     op;
    logic        handled;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] wval;
    logic [15:0] widx;
  } usb_event_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] reply;
    logic [15:0] dsel;
    logic [15:0] dlang;
    ep_cmd_t     ecmd;
    logic [3:0]  etgt;
    dev_state_t  state;
    logic [6:0]  addr;
    logic [7:0]  cfg;
    logic        wake;
  } usb_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  usb_standard_request_handler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Device model kept by the testbench.
  dev_state_t  dev_st = ST_UNATTACHED;
  logic [6:0]  dev_addr = '0;
  logic [7:0]  dev_cfg = '0;
  logic        dev_wake = 1'b0;
  logic [15:0] ep_halted = '0;

  usb_event_t  event_q[$];
  usb_result_t outcome_q[$];
  usb_event_t  cur_ev;

  int n_directed = 0;
  int n_total = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int cycles = 0;
  int act_seen[7];

  function automatic dev_state_t settled_state();
    if (dev_cfg != 8'd0) return ST_CONFIGURED;
    return (dev_addr != 7'd0) ? ST_ADDRESSED : ST_POWERED;
  endfunction

  // Applies one event to the device model and returns the result it should produce.
  function automatic usb_result_t usb_request_outcome(usb_event_t e);
    usb_result_t r;
    logic [3:0] ep;
    r.action = ACT_NONE;
    r.reply = '0;
    r.dsel = '0;
    r.dlang = '0;
    r.ecmd = EP_CMD_NONE;
    r.etgt = '0;
    ep = e.widx[3:0];
    case (e.op)
      OP_SUSPEND: dev_st = ST_SUSPENDED;
      OP_RESUME: dev_st = settled_state();
      OP_BUS_RESET: begin
        // Remote wakeup survives a bus reset.
        dev_st = ST_DEFAULT;
        dev_cfg = '0;
        dev_addr = '0;
        ep_halted = '0;
      end
      default: begin
        if (dev_st != ST_UNATTACHED && !e.handled) begin
          r.action = ACT_STALL;
          case (e.rcode)
            REQ_STATUS: begin
              if (e.rtype == RT_IN_DEVICE) begin
                r.reply = dev_wake ? 16'd2 : 16'd0;
                r.action = ACT_REPLY2;
              end else if (e.rtype == RT_IN_ENDPOINT) begin
                if (int'(ep) < NUM_ENDPOINTS) r.reply = {15'd0, ep_halted[ep]};
                r.action = ACT_REPLY2;
              end
            end
            REQ_FEAT_CLR, REQ_FEAT_SET: begin
              if (e.rtype == RT_OUT_DEVICE) begin
                if (e.wval == WAKEUP_FEATURE_SEL) begin
                  dev_wake = (e.rcode == REQ_FEAT_SET);
                  r.action = ACT_ACK;
                end
              end else if (e.rtype == RT_OUT_ENDPOINT) begin
                // The feature selector is not looked at for endpoints.
                if (ep != 4'd0 && int'(ep) < NUM_ENDPOINTS) begin
                  ep_halted[ep] = (e.rcode == REQ_FEAT_SET);
                  r.ecmd = (e.rcode == REQ_FEAT_SET) ? EP_CMD_HALT : EP_CMD_CLEAR;
                  r.etgt = ep;
                  r.action = ACT_ACK;
                end
              end
            end
            REQ_ADDR_SET: begin
              if (e.rtype == RT_OUT_DEVICE) begin
                dev_addr = e.wval[6:0];
                dev_st = (dev_addr != 7'd0) ? ST_ADDRESSED : ST_DEFAULT;
                r.action = ACT_ACK;
              end
            end
            REQ_GET_DESC: begin
              if (e.rtype == RT_IN_DEVICE || e.rtype == RT_IN_INTERFACE) begin
                if (e.wval == SERIAL_SELECTOR) begin
                  r.action = ACT_SERIAL;
                end else begin
                  r.dsel = e.wval;
                  r.dlang = e.widx;
                  r.action = ACT_DESC;
                end
              end
            end
            REQ_GET_CONFIG: begin
              if (e.rtype == RT_IN_DEVICE) begin
                r.reply = {8'd0, dev_cfg};
                r.action = ACT_REPLY1;
              end
            end
            REQ_SET_CONFIG: begin
              if (e.rtype == RT_OUT_DEVICE) begin
                dev_cfg = e.wval[7:0];
                dev_st = settled_state();
                r.action = ACT_ACK;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    r.state = dev_st;
    r.addr = dev_addr;
    r.cfg = dev_cfg;
    r.wake = dev_wake;
    return r;
  endfunction

  function automatic usb_event_t mk_event(opcode_t op, logic handled, logic [7:0] rt,
                                          logic [7:0] rc, logic [15:0] wv, logic [15:0] wi);
    usb_event_t e;
    e.op = op;
    e.handled = handled;
    e.rtype = rt;
    e.rcode = rc;
    e.wval = wv;
    e.widx = wi;
    return e;
  endfunction

  function automatic logic [15:0] rand_ep_index();
    logic [3:0] ep;
    ep = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                     : 4'($urandom_range(1, NUM_ENDPOINTS - 1));
    return {12'($urandom), ep};
  endfunction

  // Mostly well-formed requests with random content, some bus events and some noise.
  function automatic usb_event_t rand_event();
    usb_event_t e;
    int pick;
    logic [15:0] descs[6];
    descs = '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302, SERIAL_SELECTOR};
    pick = $urandom_range(0, 99);
    e = mk_event(OP_SETUP, ($urandom_range(0, 19) == 0), 8'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom));
    if (pick < 4) begin
      e.op = OP_SUSPEND;
    end else if (pick < 8) begin
      e.op = OP_RESUME;
    end else if (pick < 11) begin
      e.op = OP_BUS_RESET;
    end else if (pick < 86) begin
      case ($urandom_range(0, 6))
        0: begin
          e.rcode = REQ_STATUS;
          e.rtype = $urandom_range(0, 1) ? RT_IN_DEVICE : RT_IN_ENDPOINT;
          e.widx = rand_ep_index();
        end
        1, 2: begin
          e.rcode = $urandom_range(0, 1) ? REQ_FEAT_SET : REQ_FEAT_CLR;
          e.rtype = $urandom_range(0, 1) ? RT_OUT_DEVICE : RT_OUT_ENDPOINT;
          if ($urandom_range(0, 3) != 0) e.wval = WAKEUP_FEATURE_SEL;
          e.widx = rand_ep_index();
        end
        3: begin
          e.rcode = REQ_ADDR_SET;
          e.rtype = RT_OUT_DEVICE;
          if ($urandom_range(0, 3) != 0) e.wval = 16'($urandom_range(0, 127));
        end
        4: begin
          e.rcode = REQ_GET_DESC;
          e.rtype = $urandom_range(0, 1) ? RT_IN_DEVICE : RT_IN_INTERFACE;
          if ($urandom_range(0, 3) != 0) e.wval = descs[$urandom_range(0, 5)];
        end
        5: begin
          e.rcode = REQ_GET_CONFIG;
          e.rtype = RT_IN_DEVICE;
        end
        default: begin
          e.rcode = REQ_SET_CONFIG;
          e.rtype = RT_OUT_DEVICE;
          if ($urandom_range(0, 3) != 0) e.wval = 16'($urandom_range(0, 2));
        end
      endcase
    end else begin
      if ($urandom_range(0, 1)) e.rcode = 8'($urandom_range(0, 11));
    end
    return e;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    n_errors++;
    if (n_errors <= 50)
      $display("ERROR result %0d: %s is 0x%0h, expected 0x%0h", n_checked, field, got, want);
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(usb_request_outcome(cur_ev));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || event_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          cur_ev = event_q.pop_front();
          in_tdata <= {cur_ev.widx, cur_ev.wval, cur_ev.rcode, cur_ev.rtype};
          in_tuser <= {cur_ev.handled, cur_ev.op};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Monitor: checks every result transfer and stalls the output on its own pattern.
  int stall_mode = 0;
  int stall_tick = 0;

  always @(posedge clk) begin : watch
    usb_result_t got;
    usb_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.action = action_t'(out_tuser[2:0]);
        got.reply = out_tdata[15:0];
        got.dsel = out_tdata[31:16];
        got.dlang = out_tdata[47:32];
        got.ecmd = ep_cmd_t'(out_tdata[49:48]);
        got.etgt = out_tdata[53:50];
        got.state = dev_state_t'(out_tdata[56:54]);
        got.addr = out_tdata[63:57];
        got.cfg = out_tdata[71:64];
        got.wake = out_tdata[72];
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing expected, action", 16'(out_tuser), 16'd0);
        end else begin
          want = outcome_q.pop_front();
          if (got.action !== want.action)
            report_mismatch("action", 16'(got.action), 16'(want.action));
          if (got.reply !== want.reply)
            report_mismatch("reply_data", got.reply, want.reply);
          if (got.dsel !== want.dsel)
            report_mismatch("descriptor_selector", got.dsel, want.dsel);
          if (got.dlang !== want.dlang)
            report_mismatch("descriptor_language", got.dlang, want.dlang);
          if (got.ecmd !== want.ecmd)
            report_mismatch("endpoint_command", 16'(got.ecmd), 16'(want.ecmd));
          if (got.etgt !== want.etgt)
            report_mismatch("endpoint_target", 16'(got.etgt), 16'(want.etgt));
          if (got.state !== want.state)
            report_mismatch("device_state", 16'(got.state), 16'(want.state));
          if (got.addr !== want.addr)
            report_mismatch("device_address", 16'(got.addr), 16'(want.addr));
          if (got.cfg !== want.cfg)
            report_mismatch("configuration_value", 16'(got.cfg), 16'(want.cfg));
          if (got.wake !== want.wake)
            report_mismatch("remote_wakeup", 16'(got.wake), 16'(want.wake));
          if (out_tdata[79:73] !== 7'd0)
            report_mismatch("padding", 16'(out_tdata[79:73]), 16'd0);
          act_seen[want.action]++;
          n_checked++;
        end
      end
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      stall_tick++;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= stall_tick[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outcome_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // Directed part: leaves the unattached state, then walks through every request.
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_DEVICE, REQ_GET_CONFIG, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b1, RT_OUT_DEVICE, REQ_ADDR_SET, 16'h0011, 16'h0000));
    event_q.push_back(mk_event(OP_SUSPEND, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_RESUME, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    event_q.push_back(mk_event(OP_BUS_RESET, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_DEVICE, REQ_STATUS, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_DEVICE, REQ_FEAT_SET,
                               WAKEUP_FEATURE_SEL, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_DEVICE, REQ_STATUS, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_DEVICE, REQ_FEAT_CLR, 16'h0002, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_DEVICE, REQ_ADDR_SET, 16'hFFFF, 16'hFFFF));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_DEVICE, REQ_ADDR_SET, 16'hFF80, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_DEVICE, REQ_ADDR_SET, 16'h0005, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_DEVICE, REQ_SET_CONFIG, 16'hABFF, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_DEVICE, REQ_GET_CONFIG, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_ENDPOINT, REQ_FEAT_SET, 16'h0000, 16'hFFF7));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_ENDPOINT, REQ_STATUS, 16'h0000, 16'h0007));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_ENDPOINT, REQ_STATUS, 16'h0000, 16'h000F));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_ENDPOINT, REQ_FEAT_SET, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_ENDPOINT, REQ_FEAT_CLR, 16'h0000, 16'h0009));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_OUT_ENDPOINT, REQ_FEAT_CLR, 16'hFFFF, 16'h0007));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_DEVICE, REQ_GET_DESC, SERIAL_SELECTOR,
                               16'h0409));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, RT_IN_INTERFACE, REQ_GET_DESC, 16'h0100,
                               16'h0409));
    event_q.push_back(mk_event(OP_SETUP, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    event_q.push_back(mk_event(OP_SUSPEND, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_RESUME, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    event_q.push_back(mk_event(OP_BUS_RESET, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    n_directed = event_q.size();
    for (int i = 0; i < N_RANDOM; i++) event_q.push_back(rand_event());
    n_total = event_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || outcome_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Ran %0d events (%0d directed, %0d random) and checked %0d results in %0d cycles.",
             n_total, n_directed, n_total - n_directed, n_checked, cycles);
    $display("Actions: none %0d, stall %0d, ack %0d, reply1 %0d, reply2 %0d, serial %0d, desc %0d.",
             act_seen[ACT_NONE], act_seen[ACT_STALL], act_seen[ACT_ACK], act_seen[ACT_REPLY1],
             act_seen[ACT_REPLY2], act_seen[ACT_SERIAL], act_seen[ACT_DESC]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ usb_standard_request_handler.f @@
rtl/usbreq_pkg.sv
rtl/usb_standard_request_handler.sv
verif/tb_usb_standard_request_handler.sv
